// ----- rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment scan package
// Shared codes, stage record and glyph tables for the four-digit scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // Request classes carried from the split stage to the scan stage.
  localparam logic [1:0] KIND_NUM   = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_FEIL  = 2'd2;
  localparam logic [1:0] KIND_BLANK = 2'd3;

  // Opcode of a request.
  localparam logic OP_SHOW  = 1'b0;
  localparam logic OP_BLANK = 1'b1;

  localparam logic [15:0] VALUE_MAX = 16'd9999;

  // Reciprocals for exact division of values up to 9999.
  localparam logic [14:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000, rounded up
  localparam logic [13:0] RECIP_100  = 14'd10486;  // 2^20 / 100, rounded up
  localparam logic [12:0] RECIP_10   = 13'd6554;   // 2^16 / 10, rounded up

  localparam logic [7:0] SEG_ALL_OFF = 8'hFF;

  // Active-high segment masks of the two words, indexed by digit position
  // (position 3 is the thousands slot).
  localparam logic [7:0] STOP_GLYPH [0:3] = '{8'hE3, 8'hB4, 8'hF0, 8'hD5};
  localparam logic [7:0] FEIL_GLYPH [0:3] = '{8'h70, 8'h60, 8'hF1, 8'hE1};

  // One request after the split stage.
  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [13:0] num;
  } ssd_stage_t;

  // Active-high segment mask of a decimal digit.
  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h77;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'hB3;
      4'd3:    g = 8'h97;
      4'd4:    g = 8'hC6;
      4'd5:    g = 8'hD5;
      4'd6:    g = 8'hF4;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'hF7;
      4'd9:    g = 8'hC7;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ssd_split.sv -----
// ----------------------------------------------------------------------------
// Seven-segment request split stage
// Registers an accepted request, classifies it and forms its decimal quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_split (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               in_opcode,
  input  wire logic signed [15:0] in_value,
  input  wire logic               take_i,
  output logic                    busy,
  output ssd_pkg::ssd_stage_t     stage_o
);
  import ssd_pkg::*;

  ssd_stage_t  stage_r;
  ssd_stage_t  stage_nxt;
  logic        accept;
  logic        is_stop;
  logic        is_feil;
  logic        is_num;
  logic [13:0] num;
  logic [28:0] prod1000;
  logic [27:0] prod100;
  logic [26:0] prod10;

  assign busy   = stage_r.vld & ~take_i;
  assign accept = start & ~busy;

  assign is_stop = (in_value == -16'sd1);
  assign is_feil = (in_value == -16'sd2);
  assign is_num  = ~in_value[15] && (in_value <= $signed(VALUE_MAX));
  assign num     = in_value[13:0];

  // Quotients by multiplication with rounded-up reciprocals; exact below 10000.
  assign prod1000 = {15'd0, num} * {14'd0, RECIP_1000};
  assign prod100  = {14'd0, num} * {14'd0, RECIP_100};
  assign prod10   = {13'd0, num} * {14'd0, RECIP_10};

  always_comb begin
    stage_nxt = stage_r;
    if (accept) begin
      stage_nxt.q1000 = prod1000[27:24];
      stage_nxt.q100  = prod100[26:20];
      stage_nxt.q10   = prod10[25:16];
      stage_nxt.num   = num;
      if (in_opcode == OP_BLANK) begin
        stage_nxt.vld  = 1'b1;
        stage_nxt.kind = KIND_BLANK;
      end else if (is_stop) begin
        stage_nxt.vld  = 1'b1;
        stage_nxt.kind = KIND_STOP;
      end else if (is_feil) begin
        stage_nxt.vld  = 1'b1;
        stage_nxt.kind = KIND_FEIL;
      end else begin
        // Values out of range leave nothing to scan.
        stage_nxt.vld  = is_num;
        stage_nxt.kind = KIND_NUM;
      end
    end else if (take_i) begin
      stage_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

// ----- rtl/ssd_scan.sv -----
// ----------------------------------------------------------------------------
// Seven-segment scan stage
// Turns a split request into glyphs and emits its scan slots one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ssd_pkg::ssd_stage_t stage_i,
  output logic                     take_o,
  output logic                     out_valid,
  output logic [3:0]               out_digit_enable,
  output logic [7:0]               out_segments_n,
  output logic                     out_last_slot
);
  import ssd_pkg::*;

  // Slot store: glyph per position, positions still to show, blank slot flag.
  logic [7:0]  seg_r [0:3];
  logic [7:0]  seg_nxt [0:3];
  logic [3:0]  rem_r;
  logic [3:0]  rem_nxt;
  logic        blank_r;
  logic        blank_nxt;

  logic [3:0]  d3;
  logic [6:0]  t2;
  logic [9:0]  t1;
  logic [13:0] t0;
  logic [3:0]  show;

  logic        has_work;
  logic [3:0]  sel_oh;
  logic [1:0]  sel_idx;
  logic        last;

  logic        valid_r;
  logic [3:0]  en_r;
  logic [7:0]  seg_n_r;
  logic        last_r;

  // Digits from the quotients: each is a quotient less ten times the next one up.
  assign d3 = stage_i.q1000;
  assign t2 = stage_i.q100 - 7'({3'd0, stage_i.q1000} * 7'd10);
  assign t1 = stage_i.q10  - 10'({3'd0, stage_i.q100} * 10'd10);
  assign t0 = stage_i.num  - 14'({4'd0, stage_i.q10} * 14'd10);

  // Leading-zero blanking; the ones position always shows.
  assign show[3] = (d3 != 4'd0);
  assign show[2] = show[3] | (t2[3:0] != 4'd0);
  assign show[1] = show[2] | (t1[3:0] != 4'd0);
  assign show[0] = 1'b1;

  // Highest pending position goes out first.
  always_comb begin
    if (rem_r[3]) begin
      sel_oh  = 4'b1000;
      sel_idx = 2'd3;
    end else if (rem_r[2]) begin
      sel_oh  = 4'b0100;
      sel_idx = 2'd2;
    end else if (rem_r[1]) begin
      sel_oh  = 4'b0010;
      sel_idx = 2'd1;
    end else begin
      sel_oh  = {3'b000, rem_r[0]};
      sel_idx = 2'd0;
    end
  end

  assign has_work = blank_r | (|rem_r);
  assign last     = blank_r | ((rem_r & ~sel_oh) == 4'd0);
  assign take_o   = ~has_work | last;

  always_comb begin
    seg_nxt   = seg_r;
    rem_nxt   = rem_r & ~sel_oh;
    blank_nxt = 1'b0;
    if (take_o) begin
      rem_nxt = 4'd0;
      if (stage_i.vld) begin
        unique case (stage_i.kind)
          KIND_BLANK: begin
            blank_nxt = 1'b1;
          end
          KIND_STOP: begin
            seg_nxt = STOP_GLYPH;
            rem_nxt = 4'b1111;
          end
          KIND_FEIL: begin
            seg_nxt = FEIL_GLYPH;
            rem_nxt = 4'b1111;
          end
          KIND_NUM: begin
            seg_nxt[3] = digit_glyph(d3);
            seg_nxt[2] = digit_glyph(t2[3:0]);
            seg_nxt[1] = digit_glyph(t1[3:0]);
            seg_nxt[0] = digit_glyph(t0[3:0]);
            rem_nxt    = show;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 4'd0;
      blank_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      blank_r <= blank_nxt;
      valid_r <= has_work;
    end
  end

  always_ff @(posedge clk) begin
    seg_r   <= seg_nxt;
    en_r    <= blank_r ? 4'd0 : sel_oh;
    seg_n_r <= blank_r ? SEG_ALL_OFF : ~seg_r[sel_idx];
    last_r  <= last;
  end

  assign out_valid        = valid_r;
  assign out_digit_enable = en_r;
  assign out_segments_n   = seg_n_r;
  assign out_last_slot    = last_r;

endmodule

`default_nettype wire

// ----- rtl/four_digit_seven_segment_scan.sv -----
// ----------------------------------------------------------------------------
// Four-digit seven-segment scan driver
// Turns display requests into the multiplexed scan slots of a common-anode
// four-digit display.
// ----------------------------------------------------------------------------
// Usage: a request (in_opcode, in_value) transfers at a rising edge where
// start is high and busy is low. A show request with a value from 0 to 9999
// yields one slot per shown digit, thousands first, with leading zeros left
// out and the ones digit always present; -1 yields the word StoP and -2 the
// word FEIL, four slots each. A blank request yields one slot with no digit
// enabled and every segment off. Any other value is taken and dropped.
// Each slot appears on out_digit_enable, out_segments_n and out_last_slot for
// exactly one cycle, marked by out_valid; out_last_slot flags the final slot
// of a request. With the scan stage idle, a transferred request passes the split
// register, the slot store and the output registers before its first slot shows.
// Slots leave at one per cycle, so a request holds the scan stage until its
// last slot leaves: the output sequencer, emitting one slot a cycle, sets
// the rate (one to four slots per request). The next request is taken while
// the current one scans; busy rises when it must wait behind a scan.
// The receiver cannot stall. Reset empties both stages and clears out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_seven_segment_scan (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_opcode,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  output logic [3:0]              out_digit_enable,
  output logic [7:0]              out_segments_n,
  output logic                    out_last_slot
);
  import ssd_pkg::*;

  ssd_stage_t stage;
  logic       take;

  // Split stage: registers the request, classifies it and divides the value.
  ssd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_opcode(in_opcode),
    .in_value (in_value),
    .take_i   (take),
    .busy     (busy),
    .stage_o  (stage)
  );

  // Scan stage: looks up the glyphs and sends out one slot per cycle; it
  // takes the next request as it selects the current request's last slot.
  ssd_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .stage_i         (stage),
    .take_o          (take),
    .out_valid       (out_valid),
    .out_digit_enable(out_digit_enable),
    .out_segments_n  (out_segments_n),
    .out_last_slot   (out_last_slot)
  );

endmodule

`default_nettype wire

// ----- rtl/ssd_checker.sv -----
// ----------------------------------------------------------------------------
// Seven-segment scan checker
// Port-level properties of the four-digit scan driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [3:0]         out_digit_enable,
  input wire logic [7:0]         out_segments_n,
  input wire logic               out_last_slot
);

  // A scan runs without gaps, one position lower each cycle.
  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_slot |=>
      out_valid && (out_digit_enable == ($past(out_digit_enable) >> 1)))
    else $error("scan slot sequence broken");

  // A slot with no digit enabled is the blank slot.
  a_blank_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_enable == 4'd0) |->
      (out_segments_n == 8'hFF) && out_last_slot)
    else $error("blank slot malformed");

  // The final slot of a scan is the ones position or the blank slot.
  a_last_is_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_slot |->
      (out_digit_enable == 4'b0001) || (out_digit_enable == 4'b0000))
    else $error("scan ended on a position other than ones");

  // Busy only appears behind a request taken the cycle before.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind four_digit_seven_segment_scan ssd_checker u_ssd_checker (.*);

`default_nettype wire
